### rtl/mmbsh_pkg.sv
// ============================================================================
// mmbsh_pkg : shared definitions for the multi-mode byte string hash unit
// Mode codes, seeds, FNV primes and the item types passed between modules.
// ============================================================================
package mmbsh_pkg;

   typedef logic [3:0]  hash_mode_type;
   typedef logic [63:0] hash_word_type;

   // Hash mode codes as written to the mode register.
   localparam hash_mode_type MODE_DJB2     = 4'd0;
   localparam hash_mode_type MODE_DJB2A    = 4'd1;
   localparam hash_mode_type MODE_SDBM32   = 4'd2;
   localparam hash_mode_type MODE_SDBM64   = 4'd3;
   localparam hash_mode_type MODE_FNV0_32  = 4'd4;
   localparam hash_mode_type MODE_FNV0_64  = 4'd5;
   localparam hash_mode_type MODE_FNV1_32  = 4'd6;
   localparam hash_mode_type MODE_FNV1_64  = 4'd7;
   localparam hash_mode_type MODE_FNV1A_32 = 4'd8;
   localparam hash_mode_type MODE_FNV1A_64 = 4'd9;

   localparam hash_mode_type MODE_RESET = MODE_FNV1A_64;

   // Seeds.
   localparam hash_word_type SEED_DJB2    = 64'h0000_0000_0000_1505;
   localparam hash_word_type SEED_ZERO    = 64'h0000_0000_0000_0000;
   localparam hash_word_type FNV_BASIS_32 = 64'h0000_0000_811c_9dc5;
   localparam hash_word_type FNV_BASIS_64 = 64'hcbf2_9ce4_8422_2325;

   // FNV primes; the multipliers in the fold logic are shift-add forms of these.
   localparam logic [31:0] FNV_PRIME_32 = 32'h0100_0193;
   localparam logic [63:0] FNV_PRIME_64 = 64'h0000_0100_0000_01b3;

   // Result queue depth.
   localparam int unsigned RSP_QUEUE_DEPTH = 3;

   // One input item as held in the input register.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   // Status of the result queue as seen by the top level.
   typedef struct packed {
      logic       not_empty;
      logic [1:0] count;
   } rsp_queue_status_type;

endpackage : mmbsh_pkg

### rtl/mmbsh_fold.sv
// ============================================================================
// mmbsh_fold : combinational seed selection and single-byte hash update
// Folds one byte into the running hash for the selected mode.
// ============================================================================
module mmbsh_fold (
   input  mmbsh_pkg::hash_mode_type mode,
   input  logic                     at_start,
   input  mmbsh_pkg::hash_word_type running_hash,
   input  logic [7:0]               data_byte,
   output mmbsh_pkg::hash_word_type next_hash
);
   import mmbsh_pkg::*;

   hash_word_type seed;
   hash_word_type h;
   logic [31:0]   h32;
   logic [31:0]   b32;
   hash_word_type b64;
   logic [31:0]   djb_mul;
   logic [31:0]   sdbm_32;
   hash_word_type sdbm_64;
   logic [31:0]   mul32_op;
   logic [31:0]   mul32_res;
   hash_word_type mul64_op;
   hash_word_type mul64_res;
   logic          fnv_xor_first;

   // Codes beyond the defined set take the FNV-1a 64-bit arm.
   always_comb begin
      unique case (mode) inside
         MODE_DJB2, MODE_DJB2A:                        seed = SEED_DJB2;
         MODE_SDBM32, MODE_SDBM64,
         MODE_FNV0_32, MODE_FNV0_64:                   seed = SEED_ZERO;
         MODE_FNV1_32, MODE_FNV1A_32:                  seed = FNV_BASIS_32;
         default:                                      seed = FNV_BASIS_64;
      endcase
   end

   assign h   = at_start ? seed : running_hash;
   assign h32 = h[31:0];
   assign b32 = {24'd0, data_byte};
   assign b64 = {56'd0, data_byte};

   assign djb_mul = (h32 << 5) + h32;
   assign sdbm_32 = b32 + (h32 << 6) + (h32 << 16) - h32;
   assign sdbm_64 = b64 + (h << 6) + (h << 16) - h;

   // FNV-1a folds the byte in before the multiply, the others after it.
   assign fnv_xor_first = (mode != MODE_FNV0_32) && (mode != MODE_FNV0_64) &&
                          (mode != MODE_FNV1_32) && (mode != MODE_FNV1_64);
   assign mul32_op = fnv_xor_first ? (h32 ^ b32) : h32;
   assign mul64_op = fnv_xor_first ? (h ^ b64) : h;

   // Multiply by 0x01000193 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1.
   assign mul32_res = (mul32_op << 24) + (mul32_op << 8) + (mul32_op << 7) +
                      (mul32_op << 4) + (mul32_op << 1) + mul32_op;
   // Multiply by 0x100000001b3 = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1.
   assign mul64_res = (mul64_op << 40) + (mul64_op << 8) + (mul64_op << 7) +
                      (mul64_op << 5) + (mul64_op << 4) + (mul64_op << 1) +
                      mul64_op;

   always_comb begin
      unique case (mode) inside
         MODE_DJB2:                   next_hash = {32'd0, djb_mul + b32};
         MODE_DJB2A:                  next_hash = {32'd0, djb_mul ^ b32};
         MODE_SDBM32:                 next_hash = {32'd0, sdbm_32};
         MODE_SDBM64:                 next_hash = sdbm_64;
         MODE_FNV0_32, MODE_FNV1_32:  next_hash = {32'd0, mul32_res ^ b32};
         MODE_FNV0_64, MODE_FNV1_64:  next_hash = mul64_res ^ b64;
         MODE_FNV1A_32:               next_hash = {32'd0, mul32_res};
         default:                     next_hash = mul64_res;
      endcase
   end

endmodule : mmbsh_fold

### rtl/mmbsh_rsp_queue.sv
// ============================================================================
// mmbsh_rsp_queue : small result queue in front of the result channel
// Holds finished hashes so that the input side keeps flowing while the
// result side stalls.
// ============================================================================
module mmbsh_rsp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  mmbsh_pkg::hash_word_type        push_data,
   output mmbsh_pkg::rsp_queue_status_type status,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [63:0]                     rsp_hash_value
);
   import mmbsh_pkg::*;

   localparam int unsigned PTR_W = 2;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RSP_QUEUE_DEPTH - 1);

   hash_word_type    entry_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [1:0]       count_ff, count_in;
   logic             pop;

   assign rsp_valid      = (count_ff != 2'd0);
   assign rsp_hash_value = entry_ff[head_ff];
   assign pop            = rsp_valid && !rsp_stall;

   assign status.not_empty = rsp_valid;
   assign status.count     = count_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);
      end
      if (push) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PTR_W'(1);
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule : mmbsh_rsp_queue

### rtl/multi_mode_byte_string_hash_unit.sv
// ============================================================================
// multi_mode_byte_string_hash_unit : byte-serial multi-mode string hash
// Hashes a message one byte per transfer with DJB2, DJB2a, SDBM or FNV.
// ============================================================================
// The unit takes one message byte per transfer on the request channel, the
// final byte flagged by req_last_byte, and returns one 64-bit hash per
// message on the response channel; 32-bit modes are zero-extended. The mode
// register (csr_write_data, reset to FNV-1a 64-bit, codes ten to fifteen
// behave as FNV-1a 64-bit) must only be written between messages, when no
// hash is still in flight. A byte can be accepted on every clock cycle while
// req_stall is low: the accepted byte lands in an input register, and in the
// following cycle the fold logic (a shift-add form of the FNV prime or the
// DJB2/SDBM recurrence) updates the running hash, so the sustained rate is
// one byte per cycle while unstalled. A folded final byte pushes its hash into
// the result queue, which presents it on rsp_hash_value after the hashes ahead
// of it. Finished hashes wait in a three-entry queue, so bytes keep being
// accepted while the response side stalls; req_stall rises only when that
// queue, together with a hash about to be written into it, is full.
module multi_mode_byte_string_hash_unit (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value
);
   import mmbsh_pkg::*;

   // Mode register.
   hash_mode_type        hash_mode_ff;

   // Input register: the byte accepted in the previous cycle.
   logic                 stage_valid_ff;
   req_item_type         stage_item_ff;
   req_item_type         stage_item_in;

   // Running hash and the start-of-message flag.
   hash_word_type        running_hash_ff, running_hash_in;
   logic                 at_start_ff, at_start_in;

   hash_word_type        next_hash;
   logic                 req_transfer;
   logic                 stage_fold;
   logic                 stage_push;
   logic [2:0]           queue_demand;
   rsp_queue_status_type queue_status;

   // A request transfer completes when valid is high and stall is low.
   assign req_transfer = req_valid && !req_stall;

   // The staged byte is always folded in the cycle after it is accepted; a
   // final byte always pushes its hash into the result queue.
   assign stage_fold = stage_valid_ff;
   assign stage_push = stage_valid_ff && stage_item_ff.last_byte;

   // Stall when the queued hashes plus the one about to be pushed leave no
   // room for a further final byte accepted now.
   assign queue_demand = {1'b0, queue_status.count} + {2'b00, stage_push};
   assign req_stall    = (queue_demand >= 3'(RSP_QUEUE_DEPTH));

   assign stage_item_in.data_byte = req_data_byte;
   assign stage_item_in.last_byte = req_last_byte;

   mmbsh_fold u_fold (
      .mode         (hash_mode_ff),
      .at_start     (at_start_ff),
      .running_hash (running_hash_ff),
      .data_byte    (stage_item_ff.data_byte),
      .next_hash    (next_hash)
   );

   always_comb begin
      running_hash_in = running_hash_ff;
      at_start_in     = at_start_ff;
      if (stage_fold) begin
         running_hash_in = next_hash;
         at_start_in     = stage_item_ff.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_mode_ff    <= MODE_RESET;
         stage_valid_ff  <= 1'b0;
         running_hash_ff <= '0;
         at_start_ff     <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            hash_mode_ff <= csr_write_data;
         end
         stage_valid_ff  <= req_transfer;
         running_hash_ff <= running_hash_in;
         at_start_ff     <= at_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         stage_item_ff <= stage_item_in;
      end
   end

   mmbsh_rsp_queue u_rsp_queue (
      .clock          (clock),
      .reset          (reset),
      .push           (stage_push),
      .push_data      (next_hash),
      .status         (queue_status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

`ifndef SYNTHESIS
   // The stall rule must keep the result queue from overflowing.
   assert property (@(posedge clock) disable iff (reset)
      queue_status.count <= 2'(RSP_QUEUE_DEPTH))
      else $error("result queue count exceeds its depth");

   // A folded final byte leaves a hash on the response channel.
   assert property (@(posedge clock) disable iff (reset)
      stage_push |=> rsp_valid)
      else $error("final byte folded but no hash presented");

   // The byte after a final byte starts a new message with the mode's seed.
   assert property (@(posedge clock) disable iff (reset)
      stage_push |=> at_start_ff)
      else $error("start-of-message flag not set after a final byte");

   // A non-final byte continues the message.
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_item_ff.last_byte) |=> !at_start_ff)
      else $error("start-of-message flag set inside a message");
`endif

endmodule : multi_mode_byte_string_hash_unit
